// File: src/ypdm_pkg.sv
`timescale 1ns / 1ps
package ypdm_pkg;

	localparam int FRAC_BITS = 6;
	localparam int ROT_W     = 12;

	// configuration register indexes
	localparam logic [2:0] CFG_MODE    = 3'd0;
	localparam logic [2:0] CFG_SELECT  = 3'd1;
	localparam logic [2:0] CFG_SPEED_X = 3'd2;
	localparam logic [2:0] CFG_SPEED_Y = 3'd3;
	localparam logic [2:0] CFG_REF_YAW = 3'd4;

	// modes
	localparam logic [2:0] MODE_OFF        = 3'd0;
	localparam logic [2:0] MODE_GYRO_HOLD  = 3'd1;
	localparam logic [2:0] MODE_TRACK_GYRO = 3'd2;
	localparam logic [2:0] MODE_TRACK_LINE = 3'd3;
	localparam logic [2:0] MODE_CHECK      = 3'd4;

	// tracker selector
	localparam logic [2:0] SEL_FRONT = 3'd0;
	localparam logic [2:0] SEL_BACK  = 3'd1;
	localparam logic [2:0] SEL_RIGHT = 3'd2;
	localparam logic [2:0] SEL_LEFT  = 3'd3;
	localparam logic [2:0] SEL_NONE  = 3'd4;

	// gains have 16 fraction bits (kp Q4.16, kd Q0.16), limits in Q6.FRAC_BITS
	localparam int YAW_LIMIT    = 30 * (1 << FRAC_BITS);
	localparam int YAW_DEADBAND = (9 * (1 << FRAC_BITS) + 5) / 10;
	localparam int LINE_LIMIT   = 20 * (1 << FRAC_BITS);
	localparam int CHECK_LIMIT  = 15 * (1 << FRAC_BITS);
	localparam int BIAS_GAIN    = 5;

	typedef struct packed {
		logic [19:0]      kp;
		logic [9:0]       ki;
		logic [15:0]      kd;
		logic [ROT_W-1:0] limit;
	} gain_t;

	localparam gain_t LINE_GAIN = '{
		kp: 20'd131072, ki: 10'd131, kd: 16'd655, limit: ROT_W'(LINE_LIMIT)};
	localparam gain_t CHECK_GAIN = '{
		kp: 20'd524288, ki: 10'd524, kd: 16'd32768, limit: ROT_W'(CHECK_LIMIT)};

	typedef enum logic [1:0] {
		ROT_ZERO,
		ROT_YAW,
		ROT_LINE
	} rot_src_t;

endpackage

// File: src/yaw_hold_pid_drive_mixer.sv
`timescale 1ns / 1ps
// channel | handshake           | payload
// --------+---------------------+-------------------------------------------
// in      | in_valid / in_stall | imu_updated, measured_yaw, bias_*, line_yaw_*,
//         |                     | double_check_error
// out     | out_valid/out_stall | drive_x, drive_y, drive_rotation,
//         |                     | zero_error_ticks
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (ready always high)
//
// One word per cycle while out_stall is low; three registers: input register,
// product register (loop state updates here), result register.
// Words that give no result are dropped after the input register.
// Reset clears the configuration to its defaults and all loop state to zero.
// Each stage holds while the stage after it is full and stalled.
module yaw_hold_pid_drive_mixer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               imu_updated,
	input  logic signed [15:0]                 measured_yaw,
	input  logic signed [15:0]                 bias_front,
	input  logic signed [15:0]                 bias_back,
	input  logic signed [15:0]                 bias_right,
	input  logic signed [15:0]                 bias_left,
	input  logic signed [15:0]                 line_yaw_x,
	input  logic signed [15:0]                 line_yaw_y,
	input  logic signed [15:0]                 double_check_error,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [15:0]                 drive_x,
	output logic signed [15:0]                 drive_y,
	output logic signed [ypdm_pkg::ROT_W-1:0]  drive_rotation,
	output logic [15:0]                        zero_error_ticks,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [2:0]                         cfg_index,
	input  logic [15:0]                        cfg_data
);
	import ypdm_pkg::*;

	localparam logic signed [15:0] YAW_DB   = 16'(YAW_DEADBAND);
	localparam logic signed [18:0] YAW_LIM  = 19'(YAW_LIMIT);
	localparam logic signed [ROT_W-1:0] ROT_MAX = ROT_W'(YAW_LIMIT);

	// configuration
	logic [2:0]         mode_q;
	logic [2:0]         sel_q;
	logic signed [15:0] speed_x_q;
	logic signed [15:0] speed_y_q;
	logic signed [15:0] ref_yaw_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_OFF;
			sel_q     <= SEL_NONE;
			speed_x_q <= '0;
			speed_y_q <= '0;
			ref_yaw_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:    mode_q    <= cfg_data[2:0];
				CFG_SELECT:  sel_q     <= cfg_data[2:0];
				CFG_SPEED_X: speed_x_q <= cfg_data;
				CFG_SPEED_Y: speed_y_q <= cfg_data;
				CFG_REF_YAW: ref_yaw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables
	logic v_s1, v_s2, out_valid_q;
	logic en1, en2, en_out;

	assign en_out   = !out_valid_q || !out_stall;
	assign en2      = !v_s2 || en_out;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	// input register
	logic               imu_s1;
	logic signed [15:0] meas_s1, bf_s1, bb_s1, br_s1, bl_s1, lyx_s1, lyy_s1, dce_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			imu_s1  <= imu_updated;
			meas_s1 <= measured_yaw;
			bf_s1   <= bias_front;
			bb_s1   <= bias_back;
			br_s1   <= bias_right;
			bl_s1   <= bias_left;
			lyx_s1  <= line_yaw_x;
			lyy_s1  <= line_yaw_y;
			dce_s1  <= double_check_error;
		end
	end

	// path decode
	logic     emit, track, on_x, line_use, chk_use, fire1;
	rot_src_t rot_src;

	assign track = (mode_q == MODE_TRACK_GYRO) || (mode_q == MODE_TRACK_LINE);
	assign on_x  = (sel_q == SEL_FRONT) || (sel_q == SEL_BACK);

	always_comb begin
		case (mode_q)
			MODE_GYRO_HOLD:  emit = imu_s1;
			MODE_TRACK_GYRO: emit = imu_s1 && (sel_q <= SEL_LEFT);
			MODE_TRACK_LINE: emit = sel_q <= SEL_LEFT;
			MODE_CHECK:      emit = 1'b1;
			default:         emit = 1'b0;
		endcase
	end

	always_comb begin
		case (mode_q)
			MODE_TRACK_GYRO: rot_src = ROT_YAW;
			MODE_TRACK_LINE: rot_src = ROT_LINE;
			MODE_CHECK:      rot_src = ROT_LINE;
			default:         rot_src = ROT_ZERO;
		endcase
	end

	assign line_use = (mode_q == MODE_TRACK_LINE) || (mode_q == MODE_CHECK);
	assign chk_use  = mode_q == MODE_CHECK;
	assign fire1    = v_s1 && en2 && emit;

	// gyro yaw: Kp 7 only, so no loop state is needed
	logic signed [16:0] yaw_diff;
	logic signed [15:0] yaw_err;
	logic signed [18:0] yaw_p;
	logic signed [ROT_W-1:0] yaw_rot;

	assign yaw_diff = 17'(ref_yaw_q) - 17'(meas_s1);

	always_comb begin
		if (yaw_diff[16] != yaw_diff[15]) begin
			yaw_err = yaw_diff[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			yaw_err = yaw_diff[15:0];
		end
	end

	assign yaw_p = (19'(yaw_err) <<< 3) - 19'(yaw_err);

	always_comb begin
		if (yaw_err < YAW_DB && yaw_err > -YAW_DB) begin
			yaw_rot = '0;
		end else if (yaw_p > YAW_LIM) begin
			yaw_rot = YAW_LIM[ROT_W-1:0];
		end else if (yaw_p < -YAW_LIM) begin
			yaw_rot = ROT_W'(-YAW_LIM);
		end else begin
			yaw_rot = yaw_p[ROT_W-1:0];
		end
	end

	// tracker bias
	logic signed [15:0] bias_sel;
	logic signed [18:0] bias_term;
	logic signed [19:0] x_pre, y_pre;

	always_comb begin
		case (sel_q)
			SEL_FRONT: bias_sel = bf_s1;
			SEL_BACK:  bias_sel = bb_s1;
			SEL_RIGHT: bias_sel = br_s1;
			SEL_LEFT:  bias_sel = bl_s1;
			default:   bias_sel = '0;
		endcase
	end

	assign bias_term = 19'(bias_sel) * 19'(BIAS_GAIN);
	assign x_pre = 20'(speed_x_q) + ((track && on_x) ? 20'(bias_term) : 20'sd0);
	assign y_pre = 20'(speed_y_q) + ((track && !on_x) ? 20'(bias_term) : 20'sd0);

	// zero-error run counter
	logic [15:0] zcount_q;
	logic [15:0] zcount_next;

	always_comb begin
		if (dce_s1 != 16'sd0) begin
			zcount_next = '0;
		end else if (zcount_q != 16'hffff) begin
			zcount_next = zcount_q + 16'd1;
		end else begin
			zcount_next = zcount_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zcount_q <= '0;
		end else if (fire1 && chk_use) begin
			zcount_q <= zcount_next;
		end
	end

	// PID loops
	logic signed [15:0]      line_err;
	logic signed [ROT_W-1:0] line_out, chk_out;

	assign line_err = (mode_q == MODE_TRACK_LINE && !on_x) ? lyx_s1 : lyy_s1;

	ypdm_pid_loop u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.gain   (LINE_GAIN),
		.run    (fire1 && line_use),
		.load   (en2),
		.err    (line_err),
		.result (line_out)
	);

	ypdm_pid_loop u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.gain   (CHECK_GAIN),
		.run    (fire1 && chk_use),
		.load   (en2),
		.err    (dce_s1),
		.result (chk_out)
	);

	// stage 2
	rot_src_t                rot_src_s2;
	logic                    add_chk_s2;
	logic signed [ROT_W-1:0] yaw_rot_s2;
	logic signed [19:0]      x_pre_s2, y_pre_s2;
	logic [15:0]             zc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			rot_src_s2 <= rot_src;
			add_chk_s2 <= chk_use;
			yaw_rot_s2 <= yaw_rot;
			x_pre_s2   <= x_pre;
			y_pre_s2   <= y_pre;
			zc_s2      <= chk_use ? zcount_next : zcount_q;
		end
	end

	// mix and saturate
	logic signed [20:0]      x_sum, y_sum;
	logic signed [15:0]      x_sat, y_sat;
	logic signed [ROT_W-1:0] rot_mux;

	assign x_sum = 21'(x_pre_s2) + (add_chk_s2 ? 21'(chk_out) : 21'sd0);
	assign y_sum = 21'(y_pre_s2);

	always_comb begin
		if (x_sum > 21'sd32767) begin
			x_sat = 16'sh7fff;
		end else if (x_sum < -21'sd32768) begin
			x_sat = 16'sh8000;
		end else begin
			x_sat = x_sum[15:0];
		end
		if (y_sum > 21'sd32767) begin
			y_sat = 16'sh7fff;
		end else if (y_sum < -21'sd32768) begin
			y_sat = 16'sh8000;
		end else begin
			y_sat = y_sum[15:0];
		end
	end

	always_comb begin
		case (rot_src_s2)
			ROT_YAW:  rot_mux = yaw_rot_s2;
			ROT_LINE: rot_mux = line_out;
			default:  rot_mux = '0;
		endcase
	end

	// result register
	logic signed [15:0]      drive_x_q, drive_y_q;
	logic signed [ROT_W-1:0] drive_rot_q;
	logic [15:0]             zc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			drive_x_q   <= x_sat;
			drive_y_q   <= y_sat;
			drive_rot_q <= rot_mux;
			zc_q        <= zc_s2;
		end
	end

	assign out_valid        = out_valid_q;
	assign drive_x          = drive_x_q;
	assign drive_y          = drive_y_q;
	assign drive_rotation   = drive_rot_q;
	assign zero_error_ticks = zc_q;

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with empty input register");

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire1 && chk_use && dce_s1 == 16'sd0 && zcount_q != 16'hffff)
		|=> zcount_q == $past(zcount_q) + 16'd1)
		else $error("zero-error counter missed a step");

	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (drive_rot_q <= ROT_MAX) && (drive_rot_q >= -ROT_MAX))
		else $error("rotation outside limit");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en_out) |=> v_s2 && $stable(x_pre_s2) && $stable(zc_s2))
		else $error("stage 2 word lost under stall");

endmodule

// File: src/ypdm_pid_loop.sv
`timescale 1ns / 1ps
module ypdm_pid_loop (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ypdm_pkg::gain_t                    gain,
	input  logic                               run,
	input  logic                               load,
	input  logic signed [15:0]                 err,
	output logic signed [ypdm_pkg::ROT_W-1:0]  result
);
	import ypdm_pkg::*;

	logic signed [15:0] last_q;
	logic signed [31:0] sum_q;

	logic signed [32:0] sum_ext;
	logic signed [31:0] sum_new;
	logic signed [16:0] diff;
	logic signed [20:0] kp_s;
	logic signed [10:0] ki_s;
	logic signed [16:0] kd_s;
	logic signed [36:0] p_w;
	logic signed [33:0] d_w;
	logic signed [42:0] i_w;

	logic signed [36:0] p_s2;
	logic signed [33:0] d_s2;
	logic signed [42:0] i_s2;

	logic signed [43:0] acc;
	logic signed [43:0] rnd;
	logic signed [27:0] q;
	logic signed [27:0] lim;

	assign sum_ext = 33'(sum_q) + 33'(err);
	always_comb begin
		if (sum_ext[32] != sum_ext[31]) begin
			sum_new = sum_ext[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sum_new = sum_ext[31:0];
		end
	end

	assign diff = 17'(err) - 17'(last_q);
	assign kp_s = signed'({1'b0, gain.kp});
	assign ki_s = signed'({1'b0, gain.ki});
	assign kd_s = signed'({1'b0, gain.kd});
	assign p_w  = 37'(kp_s) * 37'(err);
	assign d_w  = 34'(kd_s) * 34'(diff);
	assign i_w  = 43'(ki_s) * 43'(sum_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			sum_q  <= '0;
		end else if (run) begin
			last_q <= err;
			sum_q  <= sum_new;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			p_s2 <= p_w;
			d_s2 <= d_w;
			i_s2 <= i_w;
		end
	end

	// round half up, then clamp
	assign acc = 44'(p_s2) + 44'(d_s2) + 44'(i_s2);
	assign rnd = acc + 44'sd32768;
	assign q   = rnd[43:16];
	assign lim = signed'({{(28-ROT_W){1'b0}}, gain.limit});

	always_comb begin
		if (q > lim) begin
			result = lim[ROT_W-1:0];
		end else if (q < -lim) begin
			result = ROT_W'(-lim);
		end else begin
			result = q[ROT_W-1:0];
		end
	end

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!run |=> $stable(last_q) && $stable(sum_q))
		else $error("pid loop state moved without a tick");

endmodule

// File: sim/yaw_hold_pid_drive_mixer_test.sv
`timescale 1ns / 1ps
module yaw_hold_pid_drive_mixer_test;
	import ypdm_pkg::*;

	localparam int IDLE_PCT = 22;
	localparam int TICK_GOAL = 1100;
	localparam int SOAK_TICKS = 40;
	localparam longint CYCLE_LIMIT = 5_000_000;
	localparam longint YAW_KP = 7 * 65536;
	localparam logic [2:0] CFG_LAST = 3'd7;   // indexes above CFG_REF_YAW are unmapped
	localparam logic [2:0] MODE_LAST = 3'd7;
	localparam logic [2:0] SEL_LAST = 3'd7;
	localparam logic [15:0] CHECK_SEQ [6] = '{16'h0000, 16'h0000, 16'h0005,
		16'h8000, 16'h7fff, 16'h0000};

	typedef struct {
		logic imu;
		logic signed [15:0] yaw, front, back, right, left, line_x, line_y, check_err;
	} tick_t;

	typedef struct {
		logic signed [15:0] x, y;
		logic signed [ROT_W-1:0] rot;
		logic [15:0] ticks;
	} drive_t;

	typedef enum int {LOOP_YAW, LOOP_LINE, LOOP_CHECK} loop_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	tick_t in_word = '{default: '0};
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] drive_x, drive_y;
	logic signed [ROT_W-1:0] drive_rotation;
	logic [15:0] zero_error_ticks;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// mirror of the block's settings and loop state
	logic [2:0] cur_mode = MODE_OFF;
	logic [2:0] cur_select = SEL_NONE;
	longint speed_x = 0;
	longint speed_y = 0;
	longint heading = 0;
	longint loop_last [3] = '{0, 0, 0};
	longint loop_sum [3] = '{0, 0, 0};
	int unsigned zero_run = 0;

	tick_t tick_feed [$];
	drive_t drive_due [$];
	int errors = 0;
	longint cycles = 0;
	bit in_fire = 1'b0;
	bit steady = 1'b0;

	yaw_hold_pid_drive_mixer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.imu_updated(in_word.imu),
		.measured_yaw(in_word.yaw),
		.bias_front(in_word.front),
		.bias_back(in_word.back),
		.bias_right(in_word.right),
		.bias_left(in_word.left),
		.line_yaw_x(in_word.line_x),
		.line_yaw_y(in_word.line_y),
		.double_check_error(in_word.check_err),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive_x(drive_x),
		.drive_y(drive_y),
		.drive_rotation(drive_rotation),
		.zero_error_ticks(zero_error_ticks),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint pid_step(loop_t lp, longint err);
		longint kp, ki, kd, lim, db, e, prev, s, acc;
		case (lp)
		LOOP_YAW: begin
			kp = YAW_KP;
			ki = 0;
			kd = 0;
			lim = YAW_LIMIT;
			db = YAW_DEADBAND;
		end
		LOOP_LINE: begin
			kp = longint'(LINE_GAIN.kp);
			ki = longint'(LINE_GAIN.ki);
			kd = longint'(LINE_GAIN.kd);
			lim = LINE_LIMIT;
			db = 0;
		end
		default: begin
			kp = longint'(CHECK_GAIN.kp);
			ki = longint'(CHECK_GAIN.ki);
			kd = longint'(CHECK_GAIN.kd);
			lim = CHECK_LIMIT;
			db = 0;
		end
		endcase
		e = sat(err, -32768, 32767);
		prev = loop_last[lp];
		s = sat(loop_sum[lp] + e, -64'sd2147483648, 64'sd2147483647);
		if (e < db && e > -db) begin
			e = 0;
			s = 0;
			prev = 0;
		end
		acc = kp * e + kd * (e - prev) + ki * s;
		loop_last[lp] = e;
		loop_sum[lp] = s;
		return sat((acc + 32768) >>> 16, -lim, lim);
	endfunction

	function automatic void mix_tick(tick_t w);
		longint x, y, rot, chk, b;
		drive_t d;
		x = speed_x;
		y = speed_y;
		rot = 0;
		case (cur_mode)
		MODE_GYRO_HOLD: begin
			if (!w.imu)
				return;
			void'(pid_step(LOOP_YAW, heading - w.yaw));
		end
		MODE_TRACK_GYRO, MODE_TRACK_LINE: begin
			if (cur_select > SEL_LEFT || (cur_mode == MODE_TRACK_GYRO && !w.imu))
				return;
			case (cur_select)
			SEL_FRONT: b = w.front;
			SEL_BACK:  b = w.back;
			SEL_RIGHT: b = w.right;
			default:   b = w.left;
			endcase
			if (cur_select < SEL_RIGHT)
				x += BIAS_GAIN * b;
			else
				y += BIAS_GAIN * b;
			if (cur_mode == MODE_TRACK_GYRO)
				rot = pid_step(LOOP_YAW, heading - w.yaw);
			else
				rot = pid_step(LOOP_LINE, cur_select < SEL_RIGHT ? w.line_y : w.line_x);
		end
		MODE_CHECK: begin
			chk = pid_step(LOOP_CHECK, w.check_err);
			if (w.check_err == 0) begin
				if (zero_run < 65535)
					zero_run++;
			end else begin
				zero_run = 0;
			end
			rot = pid_step(LOOP_LINE, w.line_y);
			x += chk;
		end
		default: return;
		endcase
		d.x = 16'(sat(x, -32768, 32767));
		d.y = 16'(sat(y, -32768, 32767));
		d.rot = ROT_W'(rot);
		d.ticks = 16'(zero_run);
		drive_due.push_back(d);
	endfunction

	function automatic void store_setting(logic [2:0] idx, logic [15:0] data);
		case (idx)
		CFG_MODE:    cur_mode = data[2:0];
		CFG_SELECT:  cur_select = data[2:0];
		CFG_SPEED_X: speed_x = longint'(signed'(data));
		CFG_SPEED_Y: speed_y = longint'(signed'(data));
		CFG_REF_YAW: heading = longint'(signed'(data));
		default: ;
		endcase
	endfunction

	function automatic logic [15:0] rand16();
		case ($urandom_range(7))
		0: return 16'h8000;
		1: return 16'h7fff;
		2: return 16'(int'($urandom_range(4)) - 2);
		3, 4: return 16'(int'($urandom_range(1023)) - 512);
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic tick_t rand_tick();
		tick_t w;
		w.imu = $urandom_range(99) < 85;
		// often close to the held heading so the deadband edge gets hit
		w.yaw = $urandom_range(9) < 4 ? 16'(heading + int'($urandom_range(160)) - 80) : rand16();
		w.front = rand16();
		w.back = rand16();
		w.right = rand16();
		w.left = rand16();
		w.line_x = rand16();
		w.line_y = rand16();
		w.check_err = $urandom_range(3) == 0 ? 16'h0000 : rand16();
		return w;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_all(input logic [2:0] m, input logic [2:0] s, input logic [15:0] sx,
			input logic [15:0] sy, input logic [15:0] h);
		write_reg(CFG_MODE, {13'($urandom), m});
		write_reg(CFG_SELECT, {13'($urandom), s});
		write_reg(CFG_SPEED_X, sx);
		write_reg(CFG_SPEED_Y, sy);
		write_reg(CFG_REF_YAW, h);
	endtask

	// drained: nothing queued, nothing in flight, then room for dropped words
	task automatic wait_idle();
		do begin
			do @(negedge clk); while (tick_feed.size() != 0 || in_valid || drive_due.size() != 0);
			repeat (8) @(negedge clk);
		end while (tick_feed.size() != 0 || in_valid || drive_due.size() != 0);
	endtask

	always @(posedge clk) begin : watch
		drive_t want;
		in_fire = arst_n && in_valid && !in_stall;
		if (in_fire)
			mix_tick(in_word);
		if (arst_n && cfg_valid && cfg_ready)
			store_setting(cfg_index, cfg_data);
		if (arst_n && out_valid && !out_stall) begin
			if (drive_due.size() == 0) begin
				errors++;
				$error("drive word with no tick pending: x %0d y %0d rot %0d ticks %0d",
					drive_x, drive_y, drive_rotation, zero_error_ticks);
			end else begin
				want = drive_due.pop_front();
				if (drive_x !== want.x) begin
					errors++;
					$error("drive_x expected %0d got %0d", want.x, drive_x);
				end
				if (drive_y !== want.y) begin
					errors++;
					$error("drive_y expected %0d got %0d", want.y, drive_y);
				end
				if (drive_rotation !== want.rot) begin
					errors++;
					$error("drive_rotation expected %0d got %0d", want.rot, drive_rotation);
				end
				if (zero_error_ticks !== want.ticks) begin
					errors++;
					$error("zero_error_ticks expected %0d got %0d", want.ticks, zero_error_ticks);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_fire || !in_valid) begin
			if (tick_feed.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				in_word <= tick_feed.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && !steady && ($urandom_range(99) < IDLE_PCT);
	end

	initial begin : timeout
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		tick_t w;
		int m_pick, n, pause_at, queued;
		logic [2:0] m, s;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// off after reset: no drive word
		tick_feed.push_back(rand_tick());
		wait_idle();
		write_reg(CFG_LAST, 16'($urandom));

		// gyro hold: deadband edges, error clamp, no fresh sample
		set_all(MODE_GYRO_HOLD, SEL_NONE, 16'h7fff, 16'h8000, 16'h0000);
		w = rand_tick();
		w.imu = 1'b1;
		w.yaw = 16'(YAW_DEADBAND - 1);
		tick_feed.push_back(w);
		w.yaw = 16'(-YAW_DEADBAND);
		tick_feed.push_back(w);
		w.yaw = 16'h8000;
		tick_feed.push_back(w);
		w.imu = 1'b0;
		tick_feed.push_back(w);
		wait_idle();

		// tracker + gyro, each tracker, speeds saturating
		for (int k = SEL_FRONT; k <= SEL_LEFT; k++) begin
			set_all(MODE_TRACK_GYRO, 3'(k), k[0] ? 16'h8000 : 16'h7fff,
				k[0] ? 16'h7fff : 16'h8000, 16'h8000);
			w = rand_tick();
			w.imu = 1'b1;
			w.yaw = 16'h7fff;
			w.front = 16'h7fff;
			w.back = 16'h8000;
			w.right = 16'h7fff;
			w.left = 16'h8000;
			tick_feed.push_back(w);
			wait_idle();
		end

		// tracker + line yaw, each tracker and none
		for (int k = SEL_FRONT; k <= SEL_NONE; k++) begin
			set_all(MODE_TRACK_LINE, 3'(k), rand16(), rand16(), 16'h0000);
			w = rand_tick();
			w.line_x = 16'h8000;
			w.line_y = 16'h7fff;
			tick_feed.push_back(w);
			wait_idle();
		end

		set_all(MODE_CHECK, SEL_NONE, 16'h7fff, 16'h0000, 16'h0000);
		foreach (CHECK_SEQ[i]) begin
			w = rand_tick();
			w.check_err = CHECK_SEQ[i];
			tick_feed.push_back(w);
		end
		wait_idle();

		set_all(MODE_LAST, SEL_FRONT, rand16(), rand16(), rand16());
		tick_feed.push_back(rand_tick());
		wait_idle();

		// random settings, mostly ones that produce drive words
		queued = 0;
		while (queued < TICK_GOAL) begin
			m_pick = $urandom_range(19);
			if (m_pick < 16)
				m = 3'(MODE_GYRO_HOLD + m_pick % 4);
			else if (m_pick < 18)
				m = MODE_OFF;
			else
				m = 3'($urandom_range(MODE_LAST, MODE_CHECK + 1));
			if ($urandom_range(9) < 8)
				s = 3'($urandom_range(SEL_LEFT, SEL_FRONT));
			else
				s = 3'($urandom_range(SEL_LAST, SEL_NONE));
			set_all(m, s, rand16(), rand16(), rand16());
			n = $urandom_range(60, 20);
			pause_at = $urandom_range(3) == 0 ? n / 2 : n;
			for (int k = 0; k < n; k++) begin
				if (k == pause_at)
					wait_idle();
				tick_feed.push_back(rand_tick());
			end
			queued += n;
			wait_idle();
		end

		// run without gaps: zero-error run, then extreme errors back to back
		steady = 1'b1;
		set_all(MODE_CHECK, SEL_FRONT, rand16(), rand16(), rand16());
		repeat (SOAK_TICKS) begin
			w = rand_tick();
			w.check_err = 16'h0000;
			w.line_y = 16'h7fff;
			tick_feed.push_back(w);
		end
		repeat (4) begin
			w = rand_tick();
			w.check_err = 16'h0001;
			w.line_y = 16'h8000;
			tick_feed.push_back(w);
		end
		repeat (SOAK_TICKS) begin
			w = rand_tick();
			w.check_err = 16'h8000;
			tick_feed.push_back(w);
		end
		wait_idle();
		steady = 1'b0;

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
src/ypdm_pkg.sv
src/ypdm_pid_loop.sv
src/yaw_hold_pid_drive_mixer.sv
sim/yaw_hold_pid_drive_mixer_test.sv
